/* hdl/bevq_pkg.sv */
// shared types and constants for the button event queue
`timescale 1ns / 1ps

package bevq_pkg;

    localparam int PIN_W      = 4;
    localparam int ID_W       = 32;
    localparam int TIME_W     = 32;
    localparam int AGE_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAX_SLOTS  = 4;

    localparam logic [AGE_W-1:0] AGE_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_SLOT0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_SLOT3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_THRESH   = 3'd5;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_levels;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic            has_event;
        logic [ID_W-1:0] id_mask;
        logic            pressed;
        logic            overflow;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic              is_press;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic push;
        logic shift;
    } t_q_ctrl;

endpackage

/* hdl/button_event_queue_chord_merge.sv */
// top level: button sampling, event queue and chord merge with output register
//
//   channel | direction | handshake          | word
//   in      | input     | i_in_valid/o_in_stall   | t_in_word (pin_levels, now_ms)
//   out     | output    | o_out_valid/i_out_stall | t_out_word (has_event, id_mask,
//           |           |                         |   pressed, overflow)
//   cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// a poll samples the slots, checks the queue head for age, then merges ripe events;
// slots are sampled one per cycle and
// the merge pops one cell of the queue chain per cycle.
// synchronous active-low reset clears the queue count, state, slot flags, ids and output valid.
// o_in_stall is high while a poll is in progress; a finished word waits in the
// output register and the next poll can be taken while it is stalled.
`timescale 1ns / 1ps

module button_event_queue_chord_merge import bevq_pkg::*; #(
    parameter int NUM_SLOTS   = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ACT_SLOTS = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
    localparam int SW        = (ACT_SLOTS > 1) ? $clog2(ACT_SLOTS) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_CHECK,
        ST_MERGE,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_slot;
    logic [ACT_SLOTS-1:0]  r_enable;
    logic [ACT_SLOTS-1:0]  r_pressed;
    logic [ACT_SLOTS-1:0]  r_levels;
    logic [ID_W-1:0]       r_ids [ACT_SLOTS];
    logic [AGE_W-1:0]      r_thr;
    logic [TIME_W-1:0]     r_now;
    logic                  r_has;
    logic                  r_press;
    logic [ID_W-1:0]       r_mask;
    logic                  r_ovf;
    logic                  r_out_valid;
    t_out_word             r_out;

    t_q_ctrl               w_q_ctrl;
    t_entry                w_push_entry;
    t_entry                w_head;
    logic [CW-1:0]         w_count;
    logic                  w_was;
    logic                  w_toggle;
    logic                  w_full;
    logic                  w_ripe;
    logic                  w_same;
    logic                  w_last_slot;
    logic                  w_out_free;
    logic [TIME_W-1:0]     w_age;
    logic [ACT_SLOTS-1:0]  w_new_enable;

    bevq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_q_ctrl),
        .i_entry (w_push_entry),
        .o_head  (w_head),
        .o_count (w_count)
    );

    always_comb begin
        w_was        = r_pressed[r_slot];
        // released and low is a press, pressed and high is a release
        w_toggle     = (r_state == ST_SAMPLE) && r_enable[r_slot] && (w_was == r_levels[r_slot]);
        w_full       = (w_count == CW'(QUEUE_DEPTH));
        w_age        = r_now - w_head.stamp;
        w_ripe       = (w_count != '0) && (w_age > {{(TIME_W - AGE_W){1'b0}}, r_thr});
        w_same       = (w_count != '0) && (w_head.is_press == r_press);
        w_last_slot  = (r_slot == SW'(ACT_SLOTS - 1));
        w_out_free   = !r_out_valid || !i_out_stall;
        w_new_enable = i_cfg_data[ACT_SLOTS-1:0];

        w_q_ctrl.push  = w_toggle && !w_full;
        w_q_ctrl.shift = ((r_state == ST_CHECK) && w_ripe) ||
                         ((r_state == ST_MERGE) && w_same);

        w_push_entry.ident    = r_ids[r_slot];
        w_push_entry.is_press = !w_was;
        w_push_entry.stamp    = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_enable    <= '0;
            r_pressed   <= '0;
            r_thr       <= AGE_RESET;
            r_out_valid <= 1'b0;
            for (int s = 0; s < ACT_SLOTS; s++) begin
                r_ids[s] <= '0;
            end
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_levels <= i_in.pin_levels[ACT_SLOTS-1:0];
                        r_now    <= i_in.now_ms;
                        r_slot   <= '0;
                        r_has    <= 1'b0;
                        r_press  <= 1'b0;
                        r_mask   <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= ST_SAMPLE;
                    end
                end
                ST_SAMPLE: begin
                    if (w_toggle) begin
                        r_pressed[r_slot] <= !w_was;
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (w_last_slot) begin
                        r_state <= ST_CHECK;
                    end else begin
                        r_slot <= r_slot + SW'(1);
                    end
                end
                ST_CHECK: begin
                    if (w_ripe) begin
                        r_has   <= 1'b1;
                        r_press <= w_head.is_press;
                        r_mask  <= w_head.ident;
                        r_state <= ST_MERGE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_MERGE: begin
                    // follow-on events of the same state fold into one chord
                    if (w_same) begin
                        r_mask <= r_mask | w_head.ident;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out.has_event <= r_has;
                        r_out.id_mask   <= r_mask;
                        r_out.pressed   <= r_press;
                        r_out.overflow  <= r_ovf;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    [CFG_ID_SLOT0:CFG_ID_SLOT3]: begin
                        if (int'(i_cfg_idx) < ACT_SLOTS) begin
                            r_ids[i_cfg_idx[SW-1:0]] <= i_cfg_data[ID_W-1:0];
                        end
                    end
                    CFG_SLOT_ENABLE: begin
                        // a newly enabled slot starts out released
                        r_pressed <= r_pressed & ~(w_new_enable & ~r_enable);
                        r_enable  <= w_new_enable;
                    end
                    CFG_AGE_THRESH: begin
                        r_thr <= i_cfg_data[AGE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.has_event) |-> (o_out.id_mask == '0 && !o_out.pressed))
        else $error("empty result carries id or press");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_SAMPLE))
        else $error("accepted poll did not start sampling");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |=> (w_count == $past(w_count)))
        else $error("queue moved outside a poll");

endmodule

/* hdl/bevq_cell.sv */
// one queue cell: holds an event, loads a new one or takes its neighbor's on a shift
`timescale 1ns / 1ps

module bevq_cell import bevq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_load,
    input  logic   i_shift,
    input  t_entry i_load_entry,
    input  t_entry i_next,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_entry;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* hdl/bevq_queue.sv */
// event queue as a row of cells that shifts toward the head on every pop
`timescale 1ns / 1ps

module bevq_queue import bevq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_ctrl       i_ctrl,
    input  t_entry        i_entry,
    output t_entry        o_head,
    output logic [CW-1:0] o_count
);

    t_entry        w_entries [DEPTH];
    logic [CW-1:0] r_count;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry w_next;
        logic   w_load;

        // the tail cell has no neighbor, it keeps its own word
        if (k < DEPTH - 1) begin : g_mid
            assign w_next = w_entries[k + 1];
        end else begin : g_tail
            assign w_next = w_entries[k];
        end

        assign w_load = i_ctrl.push && (r_count == CW'(k));

        bevq_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_shift      (i_ctrl.shift),
            .i_load_entry (i_entry),
            .i_next       (w_next),
            .o_entry      (w_entries[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.push && !i_ctrl.shift) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctrl.shift && !i_ctrl.push) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_head  = w_entries[0];
    assign o_count = r_count;

endmodule
